FILE: hdl/lbcd_pkg.sv
// shared constants, controller states and control structs for the cache directory
package lbcd_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 2 * KEY_W + 1;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_SCAN_RD  = 13'b0000000000010,
        S_SCAN_CMP = 13'b0000000000100,
        S_FREE     = 13'b0000000001000,
        S_LINK     = 13'b0000000010000,
        S_HIT_WR   = 13'b0000000100000,
        S_EV_RD    = 13'b0000001000000,
        S_EV_CAP   = 13'b0000010000000,
        S_MTF_RD   = 13'b0000100000000,
        S_MTF_A    = 13'b0001000000000,
        S_MTF_B    = 13'b0010000000000,
        S_DONE     = 13'b0100000000000,
        S_SPARE    = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_inc;
        logic hit_set;
        logic ev_rd;
        logic ev_cap;
        logic free_set;
        logic tag_wr;
        logic used_inc;
        logic link_first;
        logic link;
        logic mtf_rd;
        logic mtf_a;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic scan_last;
        logic used_zero;
        logic room;
        logic slot_is_mru;
    } status_t;

endpackage

FILE: hdl/lbcd_ram.sv
// generic single write port ram with registered read
module lbcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/lbcd_ctrl.sv
// controller state machine sequencing lookup, install and recency update
module lbcd_ctrl import lbcd_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t stat,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.used_zero ? S_FREE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    cmd.hit_set = 1'b1;
                    state_next  = S_HIT_WR;
                end
                else if (stat.scan_last)
                begin
                    state_next = stat.room ? S_FREE : S_EV_RD;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_FREE:
            begin
                cmd.free_set = 1'b1;
                state_next   = S_LINK;
            end
            S_LINK:
            begin
                cmd.tag_wr     = 1'b1;
                cmd.used_inc   = 1'b1;
                cmd.link_first = stat.used_zero;
                cmd.link       = !stat.used_zero;
                state_next     = S_DONE;
            end
            S_HIT_WR:
            begin
                cmd.tag_wr = 1'b1;
                state_next = S_MTF_RD;
            end
            S_EV_RD:
            begin
                cmd.ev_rd  = 1'b1;
                state_next = S_EV_CAP;
            end
            S_EV_CAP:
            begin
                cmd.ev_cap = 1'b1;
                cmd.tag_wr = 1'b1;
                state_next = S_MTF_RD;
            end
            S_MTF_RD:
            begin
                if (stat.slot_is_mru)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mtf_rd = 1'b1;
                    state_next = S_MTF_A;
                end
            end
            S_MTF_A:
            begin
                cmd.mtf_a  = 1'b1;
                state_next = S_MTF_B;
            end
            S_MTF_B:
            begin
                cmd.link   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

FILE: hdl/lbcd_dpath.sv
// datapath: tag and recency memories, request and result registers, chain ends
module lbcd_dpath import lbcd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           stat,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic [KEY_W-1:0]  file_id,
    input  logic [KEY_W-1:0]  block_num,
    input  logic              is_prefetch,
    output logic              hit,
    output logic              hit_on_prefetched,
    output logic              evicted_valid,
    output logic [KEY_W-1:0]  evicted_file_id,
    output logic [KEY_W-1:0]  evicted_block,
    output logic [7:0]        entry_slot
);

    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [SLOT_W-1:0] mru_reg;
    logic [SLOT_W-1:0] lru_reg;
    logic [SLOT_W-1:0] scan_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [KEY_W-1:0]  fid_reg;
    logic [KEY_W-1:0]  blk_reg;
    logic              pf_reg;
    logic              hit_reg;
    logic              hop_reg;
    logic              ev_reg;
    logic [KEY_W-1:0]  ev_fid_reg;
    logic [KEY_W-1:0]  ev_blk_reg;

    logic [CNT_W-1:0]  lim_eff;
    logic              tag_re;
    logic [SLOT_W-1:0] tag_raddr;
    logic [TAG_W-1:0]  tag_rdata;
    logic [TAG_W-1:0]  tag_wdata;
    logic [SLOT_W-1:0] prv_rdata;
    logic [SLOT_W-1:0] nxt_rdata;
    logic              nxt_we;
    logic [SLOT_W-1:0] nxt_waddr;
    logic [SLOT_W-1:0] nxt_wdata;
    logic              prv_we;
    logic [SLOT_W-1:0] prv_waddr;
    logic [SLOT_W-1:0] prv_wdata;
    logic              slot_is_lru;

    // limit of zero acts as one, above capacity acts as capacity
    always_comb
    begin
        if (limit_reg > CNT_W'(MAX_ENTRIES))
            lim_eff = CNT_W'(MAX_ENTRIES);
        else if (limit_reg == '0)
            lim_eff = CNT_W'(1);
        else
            lim_eff = limit_reg;
    end

    assign slot_is_lru = (slot_reg == lru_reg);

    assign stat.match       = (tag_rdata[TAG_W-1 -: KEY_W] == fid_reg)
                              && (tag_rdata[KEY_W:1] == blk_reg);
    assign stat.scan_last   = ({1'b0, scan_reg} == (used_reg - CNT_W'(1)));
    assign stat.used_zero   = (used_reg == '0);
    assign stat.room        = (used_reg < lim_eff);
    assign stat.slot_is_mru = (slot_reg == mru_reg);

    assign tag_re    = cmd.scan_rd || cmd.ev_rd;
    assign tag_raddr = cmd.ev_rd ? lru_reg : scan_reg;
    // a hit clears the prefetch mark, an install takes it from the request
    assign tag_wdata = {fid_reg, blk_reg, pf_reg & !hit_reg};

    // unlink step writes around the moved slot, link step puts it at the head
    assign nxt_we    = cmd.mtf_a || cmd.link;
    assign nxt_waddr = cmd.mtf_a ? prv_rdata : slot_reg;
    assign nxt_wdata = cmd.mtf_a ? nxt_rdata : mru_reg;
    assign prv_we    = (cmd.mtf_a && !slot_is_lru) || cmd.link;
    assign prv_waddr = cmd.mtf_a ? nxt_rdata : mru_reg;
    assign prv_wdata = cmd.mtf_a ? prv_rdata : slot_reg;

    lbcd_ram #(.WIDTH(TAG_W), .DEPTH(MAX_ENTRIES)) u_tag (
        .clk   (clk),
        .we    (cmd.tag_wr),
        .waddr (slot_reg),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    lbcd_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_next (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (cmd.mtf_rd),
        .raddr (slot_reg),
        .rdata (nxt_rdata)
    );

    lbcd_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTRIES)) u_prev (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .re    (cmd.mtf_rd),
        .raddr (slot_reg),
        .rdata (prv_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CNT_W'(MAX_ENTRIES);
            used_reg  <= '0;
            mru_reg   <= '0;
            lru_reg   <= '0;
            hit_reg   <= 1'b0;
            hop_reg   <= 1'b0;
            ev_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
                hop_reg <= 1'b0;
                ev_reg  <= 1'b0;
            end
            if (cmd.hit_set)
            begin
                hit_reg <= 1'b1;
                hop_reg <= tag_rdata[0];
            end
            if (cmd.ev_cap)
                ev_reg <= 1'b1;
            if (cmd.used_inc)
                used_reg <= used_reg + CNT_W'(1);
            if (cmd.link_first)
            begin
                mru_reg <= slot_reg;
                lru_reg <= slot_reg;
            end
            if (cmd.link)
                mru_reg <= slot_reg;
            if (cmd.mtf_a && slot_is_lru)
                lru_reg <= prv_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fid_reg    <= file_id;
            blk_reg    <= block_num;
            pf_reg     <= is_prefetch;
            scan_reg   <= '0;
            ev_fid_reg <= '0;
            ev_blk_reg <= '0;
        end
        if (cmd.scan_inc)
            scan_reg <= scan_reg + SLOT_W'(1);
        if (cmd.hit_set)
            slot_reg <= scan_reg;
        if (cmd.free_set)
            slot_reg <= used_reg[SLOT_W-1:0];
        if (cmd.ev_rd)
            slot_reg <= lru_reg;
        if (cmd.ev_cap)
        begin
            ev_fid_reg <= tag_rdata[TAG_W-1 -: KEY_W];
            ev_blk_reg <= tag_rdata[KEY_W:1];
        end
    end

    assign hit               = hit_reg;
    assign hit_on_prefetched = hop_reg;
    assign evicted_valid     = ev_reg;
    assign evicted_file_id   = ev_fid_reg;
    assign evicted_block     = ev_blk_reg;
    assign entry_slot        = 8'(slot_reg);

endmodule

FILE: hdl/lru_block_cache_directory.sv
// top level of the fully associative lru block cache directory
//
// usage: raise start with file_id, block_num and is_prefetch; the request beat is
// taken at a clock edge where start is high and busy is low. busy stays high until
// the result has been shown. the result beat is on hit, hit_on_prefetched,
// evicted_valid, evicted_file_id, evicted_block and entry_slot for exactly one
// cycle, marked by done; the receiver cannot stall, it must take it then.
// cfg_we with cfg_wdata writes cache_limit; write it only while busy is low.
// the lookup scans the tag memory through its single read port, reading then comparing
// one entry at a time; a hit stops the scan, and an empty directory skips it. one request
// is worked on at a time, the next is taken the cycle after done.
// reset clears occupancy, chain ends and sets cache_limit to 256; the memories
// are not cleared, only slots already filled are ever read.
module lru_block_cache_directory import lbcd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic [KEY_W-1:0]  file_id,
    input  logic [KEY_W-1:0]  block_num,
    input  logic              is_prefetch,
    output logic              hit,
    output logic              hit_on_prefetched,
    output logic              evicted_valid,
    output logic [KEY_W-1:0]  evicted_file_id,
    output logic [KEY_W-1:0]  evicted_block,
    output logic [7:0]        entry_slot
);

    cmd_t    cmd;
    status_t stat;

    lbcd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    lbcd_dpath u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .file_id           (file_id),
        .block_num         (block_num),
        .is_prefetch       (is_prefetch),
        .hit               (hit),
        .hit_on_prefetched (hit_on_prefetched),
        .evicted_valid     (evicted_valid),
        .evicted_file_id   (evicted_file_id),
        .evicted_block     (evicted_block),
        .entry_slot        (entry_slot)
    );

endmodule

FILE: hdl/lbcd_checker.sv
// port level checks for the cache directory, bound to the top level
module lbcd_checker import lbcd_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic             hit,
    input logic             hit_on_prefetched,
    input logic             evicted_valid,
    input logic [KEY_W-1:0] evicted_file_id,
    input logic [KEY_W-1:0] evicted_block
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request beat");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result beat longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat without request in flight");

    a_hop_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> !hit_on_prefetched)
        else $error("prefetch hit flag on a miss");

    a_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done && (hit || !evicted_valid) |-> evicted_file_id == '0 && evicted_block == '0
        && !(hit && evicted_valid))
        else $error("eviction fields set without eviction");

endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .hit               (hit),
    .hit_on_prefetched (hit_on_prefetched),
    .evicted_valid     (evicted_valid),
    .evicted_file_id   (evicted_file_id),
    .evicted_block     (evicted_block)
);

FILE: sim/tb.sv
// self-checking testbench for the lru block cache directory
module tb import lbcd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [KEY_W-1:0] fid;
        logic [KEY_W-1:0] blk;
        logic             pf;
        logic             is_cfg;
        logic [CNT_W-1:0] limit;
    } req_t;

    typedef struct {
        logic             hit;
        logic             hit_pf;
        logic             ev_valid;
        logic [KEY_W-1:0] ev_fid;
        logic [KEY_W-1:0] ev_blk;
        logic [7:0]       slot;
    } lookup_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             done;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic [KEY_W-1:0] file_id;
    logic [KEY_W-1:0] block_num;
    logic             is_prefetch;
    logic             hit;
    logic             hit_on_prefetched;
    logic             evicted_valid;
    logic [KEY_W-1:0] evicted_file_id;
    logic [KEY_W-1:0] evicted_block;
    logic [7:0]       entry_slot;

    lru_block_cache_directory dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .done              (done),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .file_id           (file_id),
        .block_num         (block_num),
        .is_prefetch       (is_prefetch),
        .hit               (hit),
        .hit_on_prefetched (hit_on_prefetched),
        .evicted_valid     (evicted_valid),
        .evicted_file_id   (evicted_file_id),
        .evicted_block     (evicted_block),
        .entry_slot        (entry_slot)
    );

    // predictor state
    logic [KEY_W-1:0] dir_file [MAX_ENTRIES];
    logic [KEY_W-1:0] dir_blk  [MAX_ENTRIES];
    logic             dir_pf   [MAX_ENTRIES];
    int               nxt      [MAX_ENTRIES];
    int               prv      [MAX_ENTRIES];
    int               mru, lru, used;
    int               limit_reg;

    req_t    pending_reqs[$];
    lookup_t expected_lookups[$];
    int      mismatches;
    int      n_lookups, n_hits, n_evicts, n_cfg;
    longint  cycles;
    bit      stim_done;
    int      quiet_lo, quiet_hi;

    // handshake tracking between driver and monitor
    bit start_hold;
    int settle;

    function automatic void touch(int s);
        int p, n;
        if (s == mru)
            return;
        p = prv[s];
        n = nxt[s];
        nxt[p] = n;
        if (s == lru)
            lru = p;
        else
            prv[n] = p;
        nxt[s] = mru;
        prv[mru] = s;
        mru = s;
    endfunction

    function automatic lookup_t predict_lookup(req_t r);
        lookup_t o;
        int lim, s;
        bit found;
        lim = limit_reg > MAX_ENTRIES ? MAX_ENTRIES : limit_reg;
        if (lim == 0)
            lim = 1;
        found = 0;
        s = 0;
        o = '{default: '0};
        for (int i = 0; i < used; i++)
            if (!found && dir_file[i] == r.fid && dir_blk[i] == r.blk)
            begin
                found = 1;
                s = i;
            end
        if (found)
        begin
            o.hit = 1;
            o.hit_pf = dir_pf[s];
            dir_pf[s] = 0;
            touch(s);
        end
        else if (used < lim)
        begin
            s = used;
            if (used == 0)
            begin
                mru = s;
                lru = s;
            end
            else
            begin
                nxt[s] = mru;
                prv[mru] = s;
                mru = s;
            end
            used++;
            dir_file[s] = r.fid;
            dir_blk[s] = r.blk;
            dir_pf[s] = r.pf;
        end
        else
        begin
            s = lru;
            o.ev_valid = 1;
            o.ev_fid = dir_file[s];
            o.ev_blk = dir_blk[s];
            touch(s);
            dir_file[s] = r.fid;
            dir_blk[s] = r.blk;
            dir_pf[s] = r.pf;
        end
        o.slot = s[7:0];
        return o;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // driver: one beat or one register write per free slot, changed on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 0;
            cfg_we <= 0;
        end
        else
        begin
            req_t r;
            bit quiet;
            bit we_now;
            quiet = cycles >= quiet_lo && cycles < quiet_hi;
            we_now = 0;
            if (!start_hold && pending_reqs.size() > 0)
            begin
                r = pending_reqs[0];
                if (r.is_cfg)
                begin
                    // write only when idle and nothing outstanding
                    if (!busy && expected_lookups.size() == 0 && settle == 0)
                    begin
                        void'(pending_reqs.pop_front());
                        we_now = 1;
                        cfg_wdata <= r.limit;
                        limit_reg = r.limit;
                        n_cfg++;
                    end
                    start <= 0;
                end
                else if (quiet || $urandom_range(99) >= 33)
                begin
                    file_id <= r.fid;
                    block_num <= r.blk;
                    is_prefetch <= r.pf;
                    start <= 1;
                    start_hold = 1;
                end
                else
                    start <= 0;
            end
            else if (!start_hold)
                start <= 0;
            cfg_we <= we_now;
            if (settle > 0)
                settle--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (start && !busy)
            begin
                req_t r;
                r = pending_reqs.pop_front();
                expected_lookups.push_back(predict_lookup(r));
                start_hold = 0;
                settle = 12;
            end
            if (done)
            begin
                lookup_t e;
                if (expected_lookups.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat at cycle %0d", cycles);
                end
                else
                begin
                    e = expected_lookups.pop_front();
                    n_lookups++;
                    n_hits += e.hit;
                    n_evicts += e.ev_valid;
                    if (hit !== e.hit || hit_on_prefetched !== e.hit_pf
                        || evicted_valid !== e.ev_valid || evicted_file_id !== e.ev_fid
                        || evicted_block !== e.ev_blk || entry_slot !== e.slot)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch beat %0d: exp h%b p%b e%b %h/%h s%0d got h%b p%b e%b %h/%h s%0d",
                                n_lookups, e.hit, e.hit_pf, e.ev_valid, e.ev_fid, e.ev_blk, e.slot,
                                hit, hit_on_prefetched, evicted_valid, evicted_file_id,
                                evicted_block, entry_slot);
                    end
                end
            end
        end
    end

    function automatic void add_lookup(logic [31:0] f, logic [31:0] b, logic p);
        req_t r;
        r = '{fid: f, blk: b, pf: p, is_cfg: 0, limit: '0};
        pending_reqs.push_back(r);
    endfunction

    function automatic void add_limit(int v);
        req_t r;
        r = '{fid: '0, blk: '0, pf: 0, is_cfg: 1, limit: v[CNT_W-1:0]};
        pending_reqs.push_back(r);
    endfunction

    // random phase over a small working set so hits, reuse and evictions all show up
    function automatic void add_random(int n, int span);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                add_lookup($urandom, $urandom, 1'($urandom_range(1)));
            else
                add_lookup(32'hA000_0000 | $urandom_range(3),
                    {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom_range(span))},
                    1'($urandom_range(1)));
        end
    endfunction

    initial
    begin
        rst_n = 0;
        start = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        file_id = '0;
        block_num = '0;
        is_prefetch = 0;
        start_hold = 0;
        settle = 0;
        cycles = 0;
        limit_reg = 256;
        used = 0;
        mru = 0;
        lru = 0;
        quiet_lo = 4000 + $urandom_range(3000);
        quiet_hi = quiet_lo + 3000;

        // directed: extremes, prefetch hits, eviction at small limits, zero and oversized limit
        add_lookup(32'h0, 32'h0, 0);
        add_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        add_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_lookup(32'h0, 32'h0, 1);
        add_lookup(32'h5555_5555, 32'hAAAA_AAAA, 1);
        add_limit(2);
        add_lookup(32'hAAAA_AAAA, 32'h5555_5555, 0);
        add_lookup(32'h0, 32'h0, 0);
        add_lookup(32'h1, 32'h2, 1);
        add_limit(0);
        add_lookup(32'h3, 32'h4, 0);
        add_lookup(32'h3, 32'h4, 1);
        add_lookup(32'h5, 32'h6, 1);
        add_limit(511);
        add_lookup(32'h7, 32'h8, 0);
        add_lookup(32'h5, 32'h6, 0);

        add_limit(4);
        add_random(120, 7);
        add_limit(1);
        add_random(40, 3);
        add_limit(256);
        add_random(140, 40);
        add_limit(12);
        add_random(130, 20);
        wait (pending_reqs.size() == 0);
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (expected_lookups.size() != 0 || settle != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d lookups checked: %0d hits, %0d evictions, %0d limit writes",
            n_lookups, n_hits, n_evicts, n_cfg);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    initial
    begin
        wait (cycles > 2000000);
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
